>>> rtl/swa_pkg.sv
// Shared types and constants of the stack workspace allocator.
package swa_pkg;

   localparam int unsigned ADDR_WIDTH          = 32;
   localparam int unsigned REQ_WIDTH           = 31;
   localparam int unsigned CSR_INDEX_WIDTH     = 2;
   localparam int unsigned TAG_BYTES           = 4;
   localparam int unsigned DEFAULT_ALIGN_BYTES = 16;
   localparam int unsigned DEFAULT_TAG_DEPTH   = 64;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_MEMORY = 2'd1,
      STATUS_BAD_FREE  = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ALLOCATE = 1'b0,
      MODE_FREE     = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REGION_START = 2'd0,
      CSR_REGION_BYTES = 2'd1,
      CSR_LIFO_CHECK   = 2'd2
   } csr_index_type;

endpackage

>>> rtl/swa_round_up.sv
// Four-stage pipeline that rounds a value up to a multiple of a constant alignment.
module swa_round_up #(
   parameter int unsigned VALUE_WIDTH = 32,
   parameter int unsigned ALIGN       = 16
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [VALUE_WIDTH-1:0] value_in,
   output logic [VALUE_WIDTH:0]   rounded_out
);

   localparam int unsigned XW     = VALUE_WIDTH + 1;
   localparam int unsigned LOGA   = $clog2(ALIGN);
   localparam int unsigned SHIFT  = XW + LOGA;
   localparam int unsigned RW     = XW + 1;
   localparam int unsigned PW     = XW + RW;
   localparam logic [63:0] RECIP  = (64'd1 << SHIFT) / 64'(ALIGN);
   localparam logic [XW-1:0] ALIGN_X = XW'(ALIGN);
   localparam logic [XW-1:0] ALIGN_M1 = XW'(ALIGN - 1);

   logic [XW-1:0] x0_ff;
   logic [XW-1:0] x1_ff;
   logic [XW-1:0] x2_ff;
   logic [XW-1:0] q_ff;
   logic [XW-1:0] pe_ff;
   logic [XW-1:0] rounded_ff;
   logic [PW-1:0] prod;
   logic [XW-1:0] q_in;
   logic [XW-1:0] pe_in;
   logic [XW-1:0] diff;
   logic [XW-1:0] rounded_in;

   // The reciprocal estimate is at most one below the true quotient.
   always_comb begin
      prod       = PW'(x0_ff) * PW'(RECIP[RW-1:0]);
      q_in       = XW'(prod >> SHIFT);
      pe_in      = XW'(q_ff * ALIGN_X);
      diff       = x2_ff - pe_ff;
      rounded_in = (diff >= ALIGN_X) ? (pe_ff + ALIGN_X) : pe_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff      <= {1'b0, value_in} + ALIGN_M1;
         q_ff       <= q_in;
         x1_ff      <= x0_ff;
         pe_ff      <= pe_in;
         x2_ff      <= x1_ff;
         rounded_ff <= rounded_in;
      end
   end

   assign rounded_out = rounded_ff;

endmodule

>>> rtl/stack_workspace_allocator_core.sv
// Top level of the stack workspace allocator: bump allocation with optional LIFO size check.
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid/req_ready    mode, request_bytes, free_address
//   rsp       out         rsp_valid/rsp_ready    status, granted_address, top_after
//   csr       in          csr_valid/csr_ready    csr_index, csr_data
//
// A request's response becomes valid once the request has passed the four-stage alignment
// pipeline and the stage that updates the top address and the size stack. One request can be
// accepted every cycle while no response waits on rsp_ready and no register write is offered.
// A register write holds off requests in its cycle and re-initializes the allocator once it
// has passed the reinit shift register, alongside the region alignment pipeline.
// Reset clears the registers and the allocator state; the size stack memory is not cleared.
// The whole request pipeline stalls while a response waits on rsp_ready.
module stack_workspace_allocator_core #(
   parameter int unsigned ALIGN_BYTES = swa_pkg::DEFAULT_ALIGN_BYTES,
   parameter int unsigned TAG_DEPTH   = swa_pkg::DEFAULT_TAG_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [swa_pkg::REQ_WIDTH-1:0]        req_request_bytes,
   input  logic [swa_pkg::ADDR_WIDTH-1:0]       req_free_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [swa_pkg::ADDR_WIDTH-1:0]       rsp_granted_address,
   output logic [swa_pkg::ADDR_WIDTH-1:0]       rsp_top_after,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swa_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [swa_pkg::ADDR_WIDTH-1:0]       csr_data
);

   import swa_pkg::*;

   localparam int unsigned AW    = ADDR_WIDTH;
   localparam int unsigned CW    = $clog2(TAG_DEPTH + 1);
   localparam int unsigned MW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
   localparam int unsigned STAGES = 4;

   logic                  advance;
   logic                  req_fire;
   logic                  csr_fire;
   logic                  cfg_write;

   logic [AW-1:0]         region_start_ff;
   logic [AW-1:0]         region_bytes_ff;
   logic                  lifo_check_ff;
   logic [STAGES-1:0]     reinit_ff;
   logic [AW-1:0]         cfg_value_in;
   logic [AW:0]           aligned;
   logic [AW:0]           region_sum;
   logic [AW-1:0]         end_init;

   logic                  vld_ff [STAGES];
   logic                  mode_ff [STAGES];
   logic [AW-1:0]         faddr_ff [STAGES];
   logic [AW-1:0]         padded;

   logic [AW-1:0]         top_ff;
   logic [AW-1:0]         end_ff;
   logic [CW-1:0]         count_ff;
   logic [AW-1:0]         tos_ff;
   logic [AW-1:0]         below_ff;
   logic [AW-1:0]         stack_mem [TAG_DEPTH];

   logic                  step;
   logic [AW:0]           next_w;
   logic [AW+1:0]         tag_w;
   logic [AW-1:0]         distance;
   logic [AW-1:0]         push_value;
   logic [CW-1:0]         count_less3;
   logic [MW-1:0]         wr_addr;
   logic [MW-1:0]         rd_addr;
   logic                  push;
   logic                  pop;
   logic [AW-1:0]         top_in;
   logic [CW-1:0]         count_in;
   status_type            status_in;
   logic [AW-1:0]         granted_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [AW-1:0]         rsp_granted_ff;
   logic [AW-1:0]         rsp_top_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign req_ready = advance && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign cfg_write = csr_fire && (csr_index == CSR_REGION_START ||
                                   csr_index == CSR_REGION_BYTES ||
                                   csr_index == CSR_LIFO_CHECK);

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_bytes_ff <= '0;
         lifo_check_ff   <= 1'b0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_REGION_START: region_start_ff <= csr_data;
            CSR_REGION_BYTES: region_bytes_ff <= csr_data;
            CSR_LIFO_CHECK:   lifo_check_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reinit_ff <= '0;
      end else begin
         reinit_ff <= {reinit_ff[STAGES-2:0], cfg_write};
      end
   end

   assign cfg_value_in = (csr_fire && csr_index == CSR_REGION_START) ? csr_data
                                                                      : region_start_ff;

   swa_round_up #(
      .VALUE_WIDTH (AW),
      .ALIGN       (ALIGN_BYTES)
   ) u_region_align (
      .clock       (clock),
      .advance     (1'b1),
      .value_in    (cfg_value_in),
      .rounded_out (aligned)
   );

   // The region ends at the raw end (saturated), unless alignment trimming leaves nothing.
   always_comb begin
      region_sum = {1'b0, region_start_ff} + {1'b0, region_bytes_ff};
      if (aligned[AW] || region_sum < aligned) begin
         end_init = aligned[AW-1:0];
      end else if (region_sum[AW]) begin
         end_init = '1;
      end else begin
         end_init = region_sum[AW-1:0];
      end
   end

   swa_round_up #(
      .VALUE_WIDTH (REQ_WIDTH),
      .ALIGN       (ALIGN_BYTES)
   ) u_request_pad (
      .clock       (clock),
      .advance     (advance),
      .value_in    (req_request_bytes),
      .rounded_out (padded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_fire;
         for (int i = 1; i < STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff[0]  <= req_mode;
         faddr_ff[0] <= req_free_address;
         for (int i = 1; i < STAGES; i++) begin
            mode_ff[i]  <= mode_ff[i-1];
            faddr_ff[i] <= faddr_ff[i-1];
         end
      end
   end

   assign step        = vld_ff[STAGES-1] && advance;
   assign count_less3 = count_ff - CW'(3);
   assign wr_addr     = count_ff[MW-1:0];
   assign rd_addr     = count_less3[MW-1:0];

   always_comb begin
      next_w     = {1'b0, top_ff} + {1'b0, padded};
      tag_w      = {1'b0, next_w} + (AW+2)'(TAG_BYTES);
      distance   = top_ff - faddr_ff[STAGES-1];
      push_value = padded + AW'(TAG_BYTES);
      push       = 1'b0;
      pop        = 1'b0;
      top_in     = top_ff;
      count_in   = count_ff;
      status_in  = STATUS_OK;
      granted_in = '0;
      if (mode_ff[STAGES-1] == MODE_ALLOCATE) begin
         if (next_w > {1'b0, end_ff}) begin
            status_in = STATUS_NO_MEMORY;
         end else if (lifo_check_ff) begin
            if (tag_w > {2'b00, end_ff} || count_ff >= CW'(TAG_DEPTH)) begin
               status_in = STATUS_NO_MEMORY;
            end else begin
               push       = 1'b1;
               count_in   = count_ff + CW'(1);
               granted_in = top_ff;
               top_in     = tag_w[AW-1:0];
            end
         end else begin
            granted_in = top_ff;
            top_in     = next_w[AW-1:0];
         end
      end else begin
         if (lifo_check_ff) begin
            if (count_ff == '0 || tos_ff != distance) begin
               status_in = STATUS_BAD_FREE;
            end else begin
               pop      = 1'b1;
               count_in = count_ff - CW'(1);
               top_in   = faddr_ff[STAGES-1];
            end
         end else begin
            top_in = faddr_ff[STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         end_ff   <= '0;
         count_ff <= '0;
      end else if (reinit_ff[STAGES-1]) begin
         top_ff   <= aligned[AW-1:0];
         end_ff   <= end_init;
         count_ff <= '0;
      end else if (step) begin
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   // The top entry and the one below it are kept in registers next to the memory.
   always_ff @(posedge clock) begin
      if (step && push) begin
         stack_mem[wr_addr] <= push_value;
         tos_ff             <= push_value;
         below_ff           <= tos_ff;
      end else if (step && pop) begin
         tos_ff   <= below_ff;
         below_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_status_ff  <= status_in;
         rsp_granted_ff <= granted_in;
         rsp_top_ff     <= top_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_top_after       = rsp_top_ff;

endmodule
